// ----- rtl/lfs_pkg.sv -----
// lfs_pkg: shared types, constants and the arctangent table of the line-following
// steering unit. Used by lfs_ctrl, lfs_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package lfs_pkg;

   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_LINE_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_HEADING = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE_SPEED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_X       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_Y       = 3'd5;

   localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
   localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
   localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
   localparam logic signed [53:0] GAIN_Q30    = 54'sd652032874;

   localparam logic signed [15:0] DIST_MAX  = 16'sd26214;
   localparam logic signed [15:0] RATE_MAX  = 16'sd25723;
   localparam logic signed [15:0] SPEED_MAX = 16'sd4096;

   localparam logic signed [60:0] GOAL_SQ_LIMIT   = 61'sd3865471;
   localparam logic signed [32:0] GOAL_AXIS_LIMIT = 33'sd1967;

   // floor(n / 100) = (n * RECIP_100) >> 32 for n below 2^26
   localparam logic [51:0] RECIP_100   = 52'd42949673;
   localparam logic signed [40:0] RATE_OFFSET = 41'sd26214400;
   localparam logic signed [20:0] QUOT_OFFSET = 21'sd262144;

   typedef enum logic [3:0] {
      MUL_NONE = 4'd0,
      MUL_QXY  = 4'd1,
      MUL_QWZ  = 4'd2,
      MUL_QWW  = 4'd3,
      MUL_QXX  = 4'd4,
      MUL_QYY  = 4'd5,
      MUL_QZZ  = 4'd6,
      MUL_CDY  = 4'd7,
      MUL_SDX  = 4'd8,
      MUL_GXX  = 4'd9,
      MUL_GYY  = 4'd10
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2,
      ACC_SUB  = 2'd3
   } acc_op_type;

   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        cap_num;
      logic        cap_den;
      logic        vec_init;
      logic        vec_step;
      logic        rot_init;
      logic        rot_step;
      logic        cap_trig;
      logic        cap_dist;
      logic        wrap_step;
      logic        rate1;
      logic        rate2;
      logic        rate3;
      logic        cap_goal;
      logic        out_load;
   } cmd_type;

   function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
      logic signed [33:0] r;
      case (i)
         5'd0:    r = 34'sd210828714;
         5'd1:    r = 34'sd124459457;
         5'd2:    r = 34'sd65760959;
         5'd3:    r = 34'sd33381290;
         5'd4:    r = 34'sd16755422;
         5'd5:    r = 34'sd8385879;
         5'd6:    r = 34'sd4193963;
         5'd7:    r = 34'sd2097109;
         5'd8:    r = 34'sd1048571;
         5'd9:    r = 34'sd524287;
         5'd10:   r = 34'sd262144;
         5'd11:   r = 34'sd131072;
         5'd12:   r = 34'sd65536;
         5'd13:   r = 34'sd32768;
         5'd14:   r = 34'sd16384;
         5'd15:   r = 34'sd8192;
         5'd16:   r = 34'sd4096;
         5'd17:   r = 34'sd2048;
         5'd18:   r = 34'sd1024;
         5'd19:   r = 34'sd512;
         5'd20:   r = 34'sd256;
         5'd21:   r = 34'sd128;
         5'd22:   r = 34'sd64;
         5'd23:   r = 34'sd32;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/line_following_steering_unit.sv -----
// line_following_steering_unit: top level; joins lfs_ctrl and lfs_datapath.
// Depends on lfs_pkg, lfs_ctrl, lfs_datapath.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | pose x/y, quaternion x/y/z/w
//   rsp     | out       | rsp_valid/stall   | linear speed, angular rate, at goal
//   csr     | in        | csr_valid/ready   | register index, write data
//
// After the input transfer the sequencer runs the quaternion products on the shared
// multiplier, the shared CORDIC unit once vectoring and once rotating, the distance
// products, the angle wrap, the rate steps and the goal test, then loads the result;
// the next pose is taken only once the sequencer is back in its idle state.
// Reset is synchronous and active high; it restores the register defaults and clears
// the kept rate. A stalled result sits in the output register while the next pose
// is taken; the sequencer waits at the end only if that register is still full.
`timescale 1ns / 1ps
module line_following_steering_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_pose_x,
   input  logic signed [31:0]            req_pose_y,
   input  logic signed [15:0]            req_quat_x,
   input  logic signed [15:0]            req_quat_y,
   input  logic signed [15:0]            req_quat_z,
   input  logic signed [15:0]            req_quat_w,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [13:0]            rsp_linear_speed,
   output logic signed [15:0]            rsp_angular_rate,
   output logic                          rsp_at_goal,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);

   lfs_pkg::cmd_type                cmd;
   logic [$clog2(CORDIC_STEPS)-1:0] iter;

   assign csr_ready = 1'b1;

   lfs_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .iter      (iter)
   );

   lfs_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .iter             (iter),
      .req_pose_x       (req_pose_x),
      .req_pose_y       (req_pose_y),
      .req_quat_x       (req_quat_x),
      .req_quat_y       (req_quat_y),
      .req_quat_z       (req_quat_z),
      .req_quat_w       (req_quat_w),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_angular_rate (rsp_angular_rate),
      .rsp_at_goal      (rsp_at_goal)
   );

endmodule

// ----- rtl/lfs_ctrl.sv -----
// lfs_ctrl: sequencer of the steering unit; issues one command word per cycle.
// Depends on lfs_pkg (cmd_type, mul_sel_type, acc_op_type).
`timescale 1ns / 1ps
module lfs_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output lfs_pkg::cmd_type                cmd,
   output logic [$clog2(CORDIC_STEPS)-1:0] iter
);

   localparam int IW = $clog2(CORDIC_STEPS);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_QUAT   = 14'b00000000000010,
      S_VINIT  = 14'b00000000000100,
      S_VITER  = 14'b00000000001000,
      S_RINIT  = 14'b00000000010000,
      S_RITER  = 14'b00000000100000,
      S_TRIG   = 14'b00000001000000,
      S_DIST   = 14'b00000010000000,
      S_WRAP   = 14'b00000100000000,
      S_RATE1  = 14'b00001000000000,
      S_RATE2  = 14'b00010000000000,
      S_RATE3  = 14'b00100000000000,
      S_GOAL   = 14'b01000000000000,
      S_FINISH = 14'b10000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [IW-1:0]     cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_iter;

   assign last_iter = (cnt_ff == IW'(CORDIC_STEPS - 1));
   assign iter      = cnt_ff;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = lfs_pkg::MUL_NONE;
      cmd.acc_op   = lfs_pkg::ACC_HOLD;
      state_in     = state_ff;
      cnt_in       = cnt_ff + IW'(1);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_QUAT;
            end
         end
         S_QUAT: begin
            case (cnt_ff[2:0])
               3'd0: cmd.mul_sel = lfs_pkg::MUL_QXY;
               3'd1: begin
                  cmd.mul_sel = lfs_pkg::MUL_QWZ;
                  cmd.acc_op  = lfs_pkg::ACC_LOAD;
               end
               3'd2: begin
                  cmd.mul_sel = lfs_pkg::MUL_QWW;
                  cmd.acc_op  = lfs_pkg::ACC_ADD;
               end
               3'd3: begin
                  cmd.mul_sel = lfs_pkg::MUL_QXX;
                  cmd.acc_op  = lfs_pkg::ACC_LOAD;
                  cmd.cap_num = 1'b1;
               end
               3'd4: begin
                  cmd.mul_sel = lfs_pkg::MUL_QYY;
                  cmd.acc_op  = lfs_pkg::ACC_ADD;
               end
               3'd5: begin
                  cmd.mul_sel = lfs_pkg::MUL_QZZ;
                  cmd.acc_op  = lfs_pkg::ACC_SUB;
               end
               3'd6: cmd.acc_op = lfs_pkg::ACC_SUB;
               default: begin
                  cmd.cap_den = 1'b1;
                  cnt_in      = '0;
                  state_in    = S_VINIT;
               end
            endcase
         end
         S_VINIT: begin
            cmd.vec_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_VITER;
         end
         S_VITER: begin
            cmd.vec_step = 1'b1;
            if (last_iter) begin
               cnt_in   = '0;
               state_in = S_RINIT;
            end
         end
         S_RINIT: begin
            cmd.rot_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_RITER;
         end
         S_RITER: begin
            cmd.rot_step = 1'b1;
            if (last_iter) begin
               cnt_in   = '0;
               state_in = S_TRIG;
            end
         end
         S_TRIG: begin
            cmd.cap_trig = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIST;
         end
         S_DIST: begin
            case (cnt_ff[1:0])
               2'd0: cmd.mul_sel = lfs_pkg::MUL_CDY;
               2'd1: begin
                  cmd.mul_sel = lfs_pkg::MUL_SDX;
                  cmd.acc_op  = lfs_pkg::ACC_LOAD;
               end
               2'd2: cmd.acc_op = lfs_pkg::ACC_SUB;
               default: begin
                  cmd.cap_dist = 1'b1;
                  cnt_in       = '0;
                  state_in     = S_WRAP;
               end
            endcase
         end
         S_WRAP: begin
            cmd.wrap_step = 1'b1;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in   = '0;
               state_in = S_RATE1;
            end
         end
         S_RATE1: begin
            cmd.rate1 = 1'b1;
            state_in  = S_RATE2;
         end
         S_RATE2: begin
            cmd.rate2 = 1'b1;
            state_in  = S_RATE3;
         end
         S_RATE3: begin
            cmd.rate3 = 1'b1;
            cnt_in    = '0;
            state_in  = S_GOAL;
         end
         S_GOAL: begin
            case (cnt_ff[1:0])
               2'd0: cmd.mul_sel = lfs_pkg::MUL_GXX;
               2'd1: begin
                  cmd.mul_sel = lfs_pkg::MUL_GYY;
                  cmd.acc_op  = lfs_pkg::ACC_LOAD;
               end
               2'd2: cmd.acc_op = lfs_pkg::ACC_ADD;
               default: begin
                  cmd.cap_goal = 1'b1;
                  cnt_in       = '0;
                  state_in     = S_FINISH;
               end
            endcase
         end
         S_FINISH: begin
            cnt_in = '0;
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            cnt_in   = '0;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/lfs_datapath.sv -----
// lfs_datapath: registers, shared multiplier/accumulator, CORDIC unit and rate path.
// Depends on lfs_pkg; driven by lfs_ctrl through cmd_type.
`timescale 1ns / 1ps
module lfs_datapath #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lfs_pkg::cmd_type                      cmd,
   input  logic [$clog2(CORDIC_STEPS)-1:0]       iter,
   input  logic signed [31:0]                    req_pose_x,
   input  logic signed [31:0]                    req_pose_y,
   input  logic signed [15:0]                    req_quat_x,
   input  logic signed [15:0]                    req_quat_y,
   input  logic signed [15:0]                    req_quat_z,
   input  logic signed [15:0]                    req_quat_w,
   input  logic                                  csr_write,
   input  logic [lfs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [31:0]                           csr_data,
   output logic signed [13:0]                    rsp_linear_speed,
   output logic signed [15:0]                    rsp_angular_rate,
   output logic                                  rsp_at_goal
);

   localparam int CW = 54;

   logic signed [31:0] line_x_ff, line_y_ff, goal_x_ff, goal_y_ff;
   logic signed [15:0] heading_ff, cruise_ff;
   logic signed [31:0] px_ff, py_ff;
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;

   logic signed [25:0] ma;
   logic signed [32:0] mb;
   logic signed [58:0] prod_ff;
   logic signed [60:0] acc_ff;

   logic signed [33:0] num_ff, den_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [33:0] z_ff, base_ff, err_ff;
   logic               zero_ff, flip_ff;
   logic signed [25:0] c_ff, s_ff;
   logic signed [15:0] dist_ff, last_rate_ff;
   logic [25:0]        n_ff;
   logic [51:0]        qp_ff;
   logic               at_goal_ff;

   logic signed [13:0] speed_out_ff;
   logic signed [15:0] rate_out_ff;
   logic               at_goal_out_ff;

   logic signed [33:0]   h28, atan_v, yaw, rot_z0;
   logic signed [CW-1:0] x_sh, y_sh, vx0, vy0, cx, sx, cr, sr;
   logic signed [32:0]   gx, gy, dy_line, dx_line;
   logic                 goal_near, rot_flip;
   logic signed [60:0]   prod_ext, dist_round;
   logic signed [40:0]   t_rate, v_rate;
   logic signed [20:0]   q_rate;
   logic signed [15:0]   rate_clip, dist_clip, speed_clip;

   assign rsp_linear_speed = speed_out_ff;
   assign rsp_angular_rate = rate_out_ff;
   assign rsp_at_goal      = at_goal_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_x_ff  <= '0;
         line_y_ff  <= '0;
         heading_ff <= '0;
         cruise_ff  <= 16'sd1229;
         goal_x_ff  <= 32'sd655360;
         goal_y_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lfs_pkg::CSR_LINE_X:       line_x_ff  <= csr_data;
            lfs_pkg::CSR_LINE_Y:       line_y_ff  <= csr_data;
            lfs_pkg::CSR_LINE_HEADING: heading_ff <= csr_data[15:0];
            lfs_pkg::CSR_CRUISE_SPEED: cruise_ff  <= csr_data[15:0];
            lfs_pkg::CSR_GOAL_X:       goal_x_ff  <= csr_data;
            lfs_pkg::CSR_GOAL_Y:       goal_y_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      h28     = 34'(heading_ff) <<< 15;
      atan_v  = lfs_pkg::atan_q28(5'(iter));
      x_sh    = x_ff >>> iter;
      y_sh    = y_ff >>> iter;
      gx      = 33'(px_ff) - 33'(goal_x_ff);
      gy      = 33'(py_ff) - 33'(goal_y_ff);
      dy_line = 33'(py_ff) - 33'(line_y_ff);
      dx_line = 33'(px_ff) - 33'(line_x_ff);
      goal_near = (gx < lfs_pkg::GOAL_AXIS_LIMIT) && (gx > -lfs_pkg::GOAL_AXIS_LIMIT) &&
                  (gy < lfs_pkg::GOAL_AXIS_LIMIT) && (gy > -lfs_pkg::GOAL_AXIS_LIMIT);

      case (cmd.mul_sel)
         lfs_pkg::MUL_QXY: begin ma = 26'(qx_ff); mb = 33'(qy_ff); end
         lfs_pkg::MUL_QWZ: begin ma = 26'(qw_ff); mb = 33'(qz_ff); end
         lfs_pkg::MUL_QWW: begin ma = 26'(qw_ff); mb = 33'(qw_ff); end
         lfs_pkg::MUL_QXX: begin ma = 26'(qx_ff); mb = 33'(qx_ff); end
         lfs_pkg::MUL_QYY: begin ma = 26'(qy_ff); mb = 33'(qy_ff); end
         lfs_pkg::MUL_QZZ: begin ma = 26'(qz_ff); mb = 33'(qz_ff); end
         lfs_pkg::MUL_CDY: begin ma = c_ff; mb = dy_line; end
         lfs_pkg::MUL_SDX: begin ma = s_ff; mb = dx_line; end
         lfs_pkg::MUL_GXX: begin ma = gx[25:0]; mb = gx; end
         lfs_pkg::MUL_GYY: begin ma = gy[25:0]; mb = gy; end
         default:          begin ma = '0; mb = '0; end
      endcase
      prod_ext = 61'(prod_ff);

      vx0 = CW'(den_ff) <<< 16;
      vy0 = CW'(num_ff) <<< 16;
      yaw = zero_ff ? 34'sd0 : (base_ff + z_ff);

      rot_flip = (h28 > lfs_pkg::HALF_PI_Q28) || (h28 < -lfs_pkg::HALF_PI_Q28);
      if (h28 > lfs_pkg::HALF_PI_Q28) begin
         rot_z0 = h28 - lfs_pkg::PI_Q28;
      end else if (h28 < -lfs_pkg::HALF_PI_Q28) begin
         rot_z0 = h28 + lfs_pkg::PI_Q28;
      end else begin
         rot_z0 = h28;
      end

      cx = flip_ff ? -x_ff : x_ff;
      sx = flip_ff ? -y_ff : y_ff;
      cr = (cx + CW'(32)) >>> 6;
      sr = (sx + CW'(32)) >>> 6;

      dist_round = (acc_ff + 61'sd8388608) >>> 24;
      if (dist_round > 61'(lfs_pkg::DIST_MAX)) begin
         dist_clip = lfs_pkg::DIST_MAX;
      end else if (dist_round < -61'(lfs_pkg::DIST_MAX)) begin
         dist_clip = -lfs_pkg::DIST_MAX;
      end else begin
         dist_clip = dist_round[15:0];
      end

      t_rate = ((41'(last_rate_ff) * 41'sd97) <<< 16) - ((41'(dist_ff) * 41'sd9) <<< 12)
             - (41'(err_ff) <<< 2) + 41'sd3276800;
      v_rate = (t_rate >>> 16) + lfs_pkg::RATE_OFFSET;

      q_rate = $signed({1'b0, qp_ff[51:32]}) - lfs_pkg::QUOT_OFFSET;
      if (q_rate > 21'(lfs_pkg::RATE_MAX)) begin
         rate_clip = lfs_pkg::RATE_MAX;
      end else if (q_rate < -21'(lfs_pkg::RATE_MAX)) begin
         rate_clip = -lfs_pkg::RATE_MAX;
      end else begin
         rate_clip = q_rate[15:0];
      end

      if (cruise_ff > lfs_pkg::SPEED_MAX) begin
         speed_clip = lfs_pkg::SPEED_MAX;
      end else if (cruise_ff < -lfs_pkg::SPEED_MAX) begin
         speed_clip = -lfs_pkg::SPEED_MAX;
      end else begin
         speed_clip = cruise_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_rate_ff <= '0;
      end else if (cmd.rate3) begin
         last_rate_ff <= rate_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         px_ff <= req_pose_x;
         py_ff <= req_pose_y;
         qx_ff <= req_quat_x;
         qy_ff <= req_quat_y;
         qz_ff <= req_quat_z;
         qw_ff <= req_quat_w;
      end

      prod_ff <= 59'(ma) * 59'(mb);
      case (cmd.acc_op)
         lfs_pkg::ACC_LOAD: acc_ff <= prod_ext;
         lfs_pkg::ACC_ADD:  acc_ff <= acc_ff + prod_ext;
         lfs_pkg::ACC_SUB:  acc_ff <= acc_ff - prod_ext;
         default: ;
      endcase

      if (cmd.cap_num) num_ff <= 34'(acc_ff <<< 1);
      if (cmd.cap_den) den_ff <= 34'(acc_ff);

      if (cmd.vec_init) begin
         zero_ff <= (num_ff == 34'sd0) && (den_ff == 34'sd0);
         z_ff    <= '0;
         if (den_ff < 34'sd0) begin
            x_ff    <= -vx0;
            y_ff    <= -vy0;
            base_ff <= (num_ff >= 34'sd0) ? lfs_pkg::PI_Q28 : -lfs_pkg::PI_Q28;
         end else begin
            x_ff    <= vx0;
            y_ff    <= vy0;
            base_ff <= '0;
         end
      end else if (cmd.vec_step) begin
         if (!y_ff[CW-1]) begin
            x_ff <= x_ff + y_sh;
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + atan_v;
         end else begin
            x_ff <= x_ff - y_sh;
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - atan_v;
         end
      end else if (cmd.rot_init) begin
         err_ff  <= yaw - h28;
         x_ff    <= lfs_pkg::GAIN_Q30;
         y_ff    <= '0;
         z_ff    <= rot_z0;
         flip_ff <= rot_flip;
      end else if (cmd.rot_step) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - y_sh;
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - atan_v;
         end else begin
            x_ff <= x_ff + y_sh;
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + atan_v;
         end
      end

      if (cmd.cap_trig) begin
         c_ff <= cr[25:0];
         s_ff <= sr[25:0];
      end
      if (cmd.cap_dist) dist_ff <= dist_clip;

      if (cmd.wrap_step) begin
         if (err_ff <= -lfs_pkg::PI_Q28) begin
            err_ff <= err_ff + lfs_pkg::TWO_PI_Q28;
         end else if (err_ff >= lfs_pkg::PI_Q28) begin
            err_ff <= err_ff - lfs_pkg::TWO_PI_Q28;
         end
      end

      if (cmd.rate1) n_ff  <= v_rate[25:0];
      if (cmd.rate2) qp_ff <= 52'(n_ff) * lfs_pkg::RECIP_100;

      if (cmd.cap_goal) at_goal_ff <= goal_near && (acc_ff < lfs_pkg::GOAL_SQ_LIMIT);

      if (cmd.out_load) begin
         speed_out_ff   <= at_goal_ff ? 14'sd0 : speed_clip[13:0];
         rate_out_ff    <= at_goal_ff ? 16'sd0 : last_rate_ff;
         at_goal_out_ff <= at_goal_ff;
      end
   end

endmodule

// ----- rtl/lfs_checker.sv -----
// lfs_checker: port-level assertions for line_following_steering_unit, and its bind.
// Depends on line_following_steering_unit ports only.
`timescale 1ns / 1ps
module lfs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [13:0] rsp_linear_speed,
   input logic signed [15:0] rsp_angular_rate,
   input logic               rsp_at_goal
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after a transfer");

   a_goal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_goal |-> rsp_linear_speed == 14'sd0 && rsp_angular_rate == 16'sd0)
      else $error("commands not zero at goal");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angular_rate <= 16'sd25723 && rsp_angular_rate >= -16'sd25723 &&
                    rsp_linear_speed <= 14'sd4096 && rsp_linear_speed >= -14'sd4096)
      else $error("command out of range");

endmodule

bind line_following_steering_unit lfs_checker u_lfs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_linear_speed (rsp_linear_speed),
   .rsp_angular_rate (rsp_angular_rate),
   .rsp_at_goal      (rsp_at_goal)
);
